/* rtl/dkm_pkg.sv */
// package for the dna k-modes clustering block: constants, types, majority vote
`timescale 1ns / 1ps
package dkm_pkg;

  localparam int StrandLen = 10;
  localparam int CodeW     = 3 * StrandLen;
  localparam int DistW     = 4;
  localparam int TallyMaxW = 17;

  localparam logic [1:0] ActLoadStrand   = 2'd0;
  localparam logic [1:0] ActLoadCentroid = 2'd1;
  localparam logic [1:0] ActRun          = 2'd2;
  localparam logic [1:0] ActNone         = 2'd3;

  localparam logic [1:0] CfgPointCount   = 2'd0;
  localparam logic [1:0] CfgClusterCount = 2'd1;
  localparam logic [1:0] CfgPassCount    = 2'd2;

  localparam logic [2:0] BaseA = 3'd0;
  localparam logic [2:0] BaseC = 3'd1;
  localparam logic [2:0] BaseG = 3'd2;
  localparam logic [2:0] BaseT = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASSIGN,
    ST_TALLY,
    ST_UPDATE,
    ST_EMIT
  } dkm_state_e;

  // data handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
    logic [DistW-1:0] best;
  } dkm_flit_t;

  // controls broadcast by the sequencer
  typedef struct packed {
    logic             load;
    logic             tally_mode;
    logic             update;
    logic [9:0]       slot;
    logic [CodeW-1:0] code;
  } dkm_ctl_t;

  // g only if strictly greatest, then a, then c, then t
  function automatic logic [2:0] majority(input logic [TallyMaxW-1:0] a,
                                          input logic [TallyMaxW-1:0] c,
                                          input logic [TallyMaxW-1:0] g,
                                          input logic [TallyMaxW-1:0] t);
    logic [2:0] r;
    if (g > c && g > a && g > t) r = BaseG;
    else if (a >= c && a >= g && a >= t) r = BaseA;
    else if (c >= a && c >= g && c >= t) r = BaseC;
    else r = BaseT;
    return r;
  endfunction

endpackage

/* rtl/dkm_in_if.sv */
// input channel: valid, ready and the load or run item
`timescale 1ns / 1ps
interface dkm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  slot;
  logic [29:0] strand_code;

  modport source (output valid, action, slot, strand_code, input ready);
  modport sink (input valid, action, slot, strand_code, output ready);
endinterface

/* rtl/dkm_out_if.sv */
// output channel: valid, ready and one centroid item
`timescale 1ns / 1ps
interface dkm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cluster_index;
  logic [29:0] centroid_code;
  logic        last;

  modport source (output valid, cluster_index, centroid_code, last, input ready);
  modport sink (input valid, cluster_index, centroid_code, last, output ready);
endinterface

/* rtl/dkm_cell.sv */
// one cluster cell: holds a centroid and its base tallies, passes strands on
`timescale 1ns / 1ps
module dkm_cell
  import dkm_pkg::*;
#(
  parameter int IdxW = 10,
  parameter int KW   = 4,
  parameter int CW   = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [KW-1:0]    cell_id_i,
  input  logic             active_i,
  input  dkm_ctl_t         ctl_i,
  input  dkm_flit_t        flit_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [KW-1:0]    pick_i,
  output dkm_flit_t        flit_o,
  output logic [IdxW-1:0]  idx_o,
  output logic [KW-1:0]    pick_o,
  output logic [CodeW-1:0] centroid_o
);

  logic [CodeW-1:0] cent_q;
  logic [CW-1:0]    tally_q [StrandLen][4];
  logic             valid_q;
  logic [CodeW-1:0] code_q;
  logic [DistW-1:0] best_q;
  logic [IdxW-1:0]  idx_q;
  logic [KW-1:0]    pick_q;
  logic [DistW-1:0] mism;
  logic [CodeW-1:0] new_cent;
  logic             hit;

  always_comb begin
    mism = '0;
    for (int p = 0; p < StrandLen; p++) begin
      if (flit_i.code[3*p +: 3] != cent_q[3*p +: 3]) mism = mism + DistW'(1);
    end
    for (int p = 0; p < StrandLen; p++) begin
      new_cent[3*p +: 3] = majority(TallyMaxW'(tally_q[p][0]), TallyMaxW'(tally_q[p][1]),
                                    TallyMaxW'(tally_q[p][2]), TallyMaxW'(tally_q[p][3]));
    end
    hit = flit_i.valid && active_i && (mism < flit_i.best);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int p = 0; p < StrandLen; p++) begin
        for (int b = 0; b < 4; b++) tally_q[p][b] <= '0;
      end
    end else begin
      valid_q <= flit_i.valid;
      if (ctl_i.update) begin
        for (int p = 0; p < StrandLen; p++) begin
          for (int b = 0; b < 4; b++) tally_q[p][b] <= '0;
        end
      end else if (ctl_i.tally_mode && flit_i.valid && pick_i == cell_id_i) begin
        for (int p = 0; p < StrandLen; p++) begin
          if (!flit_i.code[3*p+2]) begin
            tally_q[p][flit_i.code[3*p +: 2]] <= tally_q[p][flit_i.code[3*p +: 2]] + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= flit_i.code;
    idx_q  <= idx_i;
    if (!ctl_i.tally_mode && hit) begin
      best_q <= mism;
      pick_q <= cell_id_i;
    end else begin
      best_q <= flit_i.best;
      pick_q <= pick_i;
    end
    if (ctl_i.load && ctl_i.slot == 10'(cell_id_i)) cent_q <= ctl_i.code;
    else if (ctl_i.update && active_i) cent_q <= new_cent;
  end

  assign flit_o.valid = valid_q;
  assign flit_o.code  = code_q;
  assign flit_o.best  = best_q;
  assign idx_o        = idx_q;
  assign pick_o       = pick_q;
  assign centroid_o   = cent_q;

endmodule

/* rtl/dna_kmodes_clustering.sv */
// top level: strand stores, pass sequencer and the row of cluster cells
//
//   channel   direction  carries
//   in_i      sink       action, slot, strand_code
//   out_o     source     cluster_index, centroid_code, last
//   cfg_*     write      point_count, cluster_count, pass_count
//
// a run has the strand memory read port walk every strand twice per pass
// (assign, then tally) through the cell row of MAX_CLUSTERS stages, then one
// output item is emitted per centroid
// no item is accepted while a run is in progress; output stalls hold emission
// reset clears control state; stores are undefined until loaded
`timescale 1ns / 1ps
module dna_kmodes_clustering
  import dkm_pkg::*;
#(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dkm_in_if.sink      in_i,
  dkm_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i
);

  localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int KW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KCW = $clog2(MAX_CLUSTERS + 1);
  localparam int SW  = $clog2(MAX_POINTS + MAX_CLUSTERS + 2);
  localparam int NpReset = (MAX_POINTS < 1024) ? MAX_POINTS : 1024;
  localparam int NcReset = (MAX_CLUSTERS < 4) ? MAX_CLUSTERS : 4;

  // configuration; point and cluster counts saturated on write
  logic [CW-1:0]  np_q;
  logic [KCW-1:0] nc_q;
  logic [7:0]     passes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q     <= CW'(NpReset);
      nc_q     <= KCW'(NcReset);
      passes_q <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPointCount: begin
          if (32'(cfg_data_i) > MAX_POINTS) np_q <= CW'(MAX_POINTS);
          else np_q <= CW'(cfg_data_i);
        end
        CfgClusterCount: begin
          if (cfg_data_i[4:0] == 5'd0) nc_q <= KCW'(1);
          else if (32'(cfg_data_i[4:0]) > MAX_CLUSTERS) nc_q <= KCW'(MAX_CLUSTERS);
          else nc_q <= KCW'(cfg_data_i[4:0]);
        end
        CfgPassCount: passes_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer
  dkm_state_e    state_q, state_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [7:0]    pass_q, pass_d;
  logic [KW-1:0] emit_k_q, emit_k_d;
  logic          in_acc;
  logic          emit_fire;
  logic          emit_last;
  logic          walking;
  logic          phase_end;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign walking   = (state_q == ST_ASSIGN) || (state_q == ST_TALLY);
  // phase ends when the last strand leaves the final cell of the row
  assign phase_end = (cnt_q == SW'(np_q) + SW'(MAX_CLUSTERS));
  assign emit_fire = (state_q == ST_EMIT) && (!out_o.valid || out_o.ready);
  assign emit_last = (32'(emit_k_q) + 1 == 32'(nc_q));

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pass_d   = pass_q;
    emit_k_d = emit_k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.action == ActRun) begin
          pass_d   = '0;
          cnt_d    = '0;
          emit_k_d = '0;
          state_d  = (passes_q == 8'd0) ? ST_EMIT : ST_ASSIGN;
        end
      end
      ST_ASSIGN: begin
        cnt_d = cnt_q + SW'(1);
        if (phase_end) begin
          cnt_d   = '0;
          state_d = ST_TALLY;
        end
      end
      ST_TALLY: begin
        cnt_d = cnt_q + SW'(1);
        if (phase_end) begin
          cnt_d   = '0;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        pass_d  = pass_q + 8'd1;
        state_d = (pass_q + 8'd1 == passes_q) ? ST_EMIT : ST_ASSIGN;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          emit_k_d = emit_k_q + KW'(1);
          if (emit_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pass_q   <= '0;
      emit_k_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pass_q   <= pass_d;
      emit_k_q <= emit_k_d;
    end
  end

  // strand and member memories, registered reads
  logic [CodeW-1:0] strand_mem [MAX_POINTS];
  logic [KW-1:0]    member_mem [MAX_POINTS];
  logic [CodeW-1:0] strand_rd_q;
  logic [KW-1:0]    member_rd_q;
  logic [PW-1:0]    rd_idx_q;
  logic             rd_v_q;
  logic             issue;
  logic [PW-1:0]    rd_addr;

  assign issue   = walking && (cnt_q < SW'(np_q));
  assign rd_addr = cnt_q[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.action == ActLoadStrand && 32'(in_i.slot) < MAX_POINTS) begin
      strand_mem[PW'(in_i.slot)] <= in_i.strand_code;
    end
    strand_rd_q <= strand_mem[rd_addr];
    member_rd_q <= member_mem[rd_addr];
    rd_idx_q    <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_v_q <= 1'b0;
    else rd_v_q <= issue;
  end

  // cell row
  dkm_ctl_t         ctl;
  dkm_flit_t        flit   [MAX_CLUSTERS+1];
  logic [PW-1:0]    idx    [MAX_CLUSTERS+1];
  logic [KW-1:0]    pick   [MAX_CLUSTERS+1];
  logic [CodeW-1:0] cent_w [MAX_CLUSTERS];

  always_comb begin
    ctl.load       = in_acc && (in_i.action == ActLoadCentroid) &&
                     (32'(in_i.slot) < MAX_CLUSTERS);
    ctl.tally_mode = (state_q == ST_TALLY);
    ctl.update     = (state_q == ST_UPDATE);
    ctl.slot       = in_i.slot;
    ctl.code       = in_i.strand_code;
  end

  assign flit[0].valid = rd_v_q;
  assign flit[0].code  = strand_rd_q;
  // search starts above the largest possible distance
  assign flit[0].best  = DistW'(StrandLen + 1);
  assign idx[0]        = rd_idx_q;
  assign pick[0]       = (state_q == ST_TALLY) ? member_rd_q : '0;

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
    dkm_cell #(
      .IdxW (PW),
      .KW   (KW),
      .CW   (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_id_i  (KW'(k)),
      .active_i   (k < 32'(nc_q)),
      .ctl_i      (ctl),
      .flit_i     (flit[k]),
      .idx_i      (idx[k]),
      .pick_i     (pick[k]),
      .flit_o     (flit[k+1]),
      .idx_o      (idx[k+1]),
      .pick_o     (pick[k+1]),
      .centroid_o (cent_w[k])
    );
  end

  // nearest cluster of each strand lands in the member store at the row tail
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ASSIGN && flit[MAX_CLUSTERS].valid) begin
      member_mem[idx[MAX_CLUSTERS]] <= pick[MAX_CLUSTERS];
    end
  end

  // output register
  logic        out_v_q;
  logic [3:0]  out_k_q;
  logic [29:0] out_code_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (emit_fire) out_v_q <= 1'b1;
    else if (out_o.ready) out_v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_k_q    <= 4'(emit_k_q);
      out_code_q <= cent_w[emit_k_q];
      out_last_q <= emit_last;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.cluster_index = out_k_q;
  assign out_o.centroid_code = out_code_q;
  assign out_o.last          = out_last_q;

endmodule
